// ===== src/dqsp_pkg.sv =====
// Shared constants, codes and request/result types for the double-ended queue.
package dqsp_pkg;

  localparam int DEPTH  = 16;
  localparam int ITEM_W = 32;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ACT_W  = 3;
  localparam int STAT_W = 2;

  localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_POP_BACK   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_COUNT      = 3'd4;
  localparam logic [ACT_W-1:0] ACT_PURGE      = 3'd5;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_RD_FRONT,
    S_RD_BACK,
    S_RD_LAST,
    S_OUT
  } dqsp_state_t;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [ITEM_W-1:0] item;
  } dqsp_in_t;

  typedef struct packed {
    logic [ITEM_W-1:0] front_item;
    logic [ITEM_W-1:0] back_item;
    logic [CNT_W-1:0]  entry_count;
    logic              is_empty;
    logic [CNT_W-1:0]  match_count;
    logic [STAT_W-1:0] status;
  } dqsp_out_t;

endpackage

// ===== src/dqsp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dqsp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== src/deque_with_search_and_purge.sv =====
// Top level of the bounded double-ended queue with count and purge requests.
//
// One request is taken when start is high and busy is low; busy then stays high
// until the result has been shown. The result appears on out_res for exactly one
// cycle with out_valid high and cannot be held off. Push, pop and unused action
// codes go from the execute state through the front, back and last read states
// to the output state. Count and purge add a scan state that walks the N stored
// entries through the single read port of the entry RAM, one entry per cycle with
// the compare of the previous read overlapped. The entry RAM needs no clearing
// after reset.
module deque_with_search_and_purge
  import dqsp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  dqsp_in_t  in_req,
  output logic      busy,
  output logic      out_valid,
  output dqsp_out_t out_res
);

  dqsp_state_t       state_r, state_nxt;
  logic [ACT_W-1:0]  act_r;
  logic [ITEM_W-1:0] item_r;
  logic [IDX_W-1:0]  front_r, front_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt;
  logic [CNT_W-1:0]  kept_r, kept_nxt;
  logic [CNT_W-1:0]  match_r, match_nxt;
  logic              pend_r, pend_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic [ITEM_W-1:0] fitem_r, fitem_nxt;
  logic [ITEM_W-1:0] bitem_r, bitem_nxt;

  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [ITEM_W-1:0] wr_data;
  logic [IDX_W-1:0]  rd_addr;
  logic [ITEM_W-1:0] rd_data;
  logic              accept;
  logic              hit;
  logic              scan_done;

  assign accept    = start && (state_r == S_IDLE);
  assign hit       = (rd_data == item_r);
  assign scan_done = (k_r == cnt_r) && !pend_r;

  dqsp_ram #(
    .WIDTH(ITEM_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if ((act_r == ACT_COUNT) || (act_r == ACT_PURGE)) begin
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_RD_FRONT;
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_nxt = S_RD_FRONT;
        end
      end
      S_RD_FRONT: state_nxt = S_RD_BACK;
      S_RD_BACK:  state_nxt = S_RD_LAST;
      S_RD_LAST:  state_nxt = S_OUT;
      S_OUT:      state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    front_nxt  = front_r;
    cnt_nxt    = cnt_r;
    k_nxt      = k_r;
    kept_nxt   = kept_r;
    match_nxt  = match_r;
    pend_nxt   = 1'b0;
    status_nxt = status_r;
    fitem_nxt  = fitem_r;
    bitem_nxt  = bitem_r;
    wr_en      = 1'b0;
    wr_addr    = front_r + kept_r[IDX_W-1:0];
    wr_data    = item_r;
    rd_addr    = front_r + k_r[IDX_W-1:0];
    case (state_r)
      S_EXEC: begin
        status_nxt = ST_DONE;
        match_nxt  = '0;
        k_nxt      = '0;
        kept_nxt   = '0;
        case (act_r)
          ACT_PUSH_FRONT: begin
            if (cnt_r == CNT_FULL) begin
              status_nxt = ST_FULL;
            end else begin
              front_nxt = front_r - IDX_W'(1);
              wr_en     = 1'b1;
              wr_addr   = front_r - IDX_W'(1);
              cnt_nxt   = cnt_r + CNT_W'(1);
            end
          end
          ACT_PUSH_BACK: begin
            if (cnt_r == CNT_FULL) begin
              status_nxt = ST_FULL;
            end else begin
              wr_en   = 1'b1;
              wr_addr = front_r + cnt_r[IDX_W-1:0];
              cnt_nxt = cnt_r + CNT_W'(1);
            end
          end
          ACT_POP_FRONT: begin
            if (cnt_r == '0) begin
              status_nxt = ST_EMPTY;
            end else begin
              front_nxt = front_r + IDX_W'(1);
              cnt_nxt   = cnt_r - CNT_W'(1);
            end
          end
          ACT_POP_BACK: begin
            if (cnt_r == '0) begin
              status_nxt = ST_EMPTY;
            end else begin
              cnt_nxt = cnt_r - CNT_W'(1);
            end
          end
          default: begin
          end
        endcase
      end
      S_SCAN: begin
        // issue the next read while the previous one is compared
        if (k_r != cnt_r) begin
          k_nxt    = k_r + CNT_W'(1);
          pend_nxt = 1'b1;
        end
        if (pend_r) begin
          if (hit) begin
            match_nxt = match_r + CNT_W'(1);
          end else if (act_r == ACT_PURGE) begin
            wr_en    = 1'b1;
            wr_data  = rd_data;
            kept_nxt = kept_r + CNT_W'(1);
          end
        end
        if (scan_done && (act_r == ACT_PURGE)) begin
          cnt_nxt = kept_r;
        end
      end
      S_RD_FRONT: begin
        rd_addr = front_r;
      end
      S_RD_BACK: begin
        rd_addr   = front_r + cnt_r[IDX_W-1:0] - IDX_W'(1);
        fitem_nxt = (cnt_r == '0) ? '0 : rd_data;
      end
      S_RD_LAST: begin
        bitem_nxt = (cnt_r == '0) ? '0 : rd_data;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      front_r  <= '0;
      cnt_r    <= '0;
      k_r      <= '0;
      kept_r   <= '0;
      match_r  <= '0;
      pend_r   <= 1'b0;
      status_r <= ST_DONE;
    end else begin
      state_r  <= state_nxt;
      front_r  <= front_nxt;
      cnt_r    <= cnt_nxt;
      k_r      <= k_nxt;
      kept_r   <= kept_nxt;
      match_r  <= match_nxt;
      pend_r   <= pend_nxt;
      status_r <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r  <= in_req.action;
      item_r <= in_req.item;
    end
    fitem_r <= fitem_nxt;
    bitem_r <= bitem_nxt;
  end

  assign busy                = (state_r != S_IDLE);
  assign out_valid           = (state_r == S_OUT);
  assign out_res.front_item  = fitem_r;
  assign out_res.back_item   = bitem_r;
  assign out_res.entry_count = cnt_r;
  assign out_res.is_empty    = (cnt_r == '0);
  assign out_res.match_count = match_r;
  assign out_res.status      = status_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL)
    else $error("entry count above depth");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after request");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy)
    else $error("result strobe longer than one cycle");

  a_reject_no_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_res.status != ST_DONE) |-> out_res.match_count == '0)
    else $error("rejected request reports matches");

  a_purge_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) && scan_done && (act_r == ACT_PURGE)
      |=> cnt_r + match_r == $past(cnt_r))
    else $error("purge count mismatch");

endmodule
